// ===== src/keyed_watermark_cell_pattern_top_assert.svh =====
// Assertion macros used by the RTL controller
`ifndef KEYED_WATERMARK_CELL_PATTERN_TOP_ASSERT_SVH
`define KEYED_WATERMARK_CELL_PATTERN_TOP_ASSERT_SVH

// a implies b on the same edge
`define KWCP_ASSERT_IMPL(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// a implies b on the next edge
`define KWCP_ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

// ===== src/kwcp_pkg.sv =====
// Package: shared constants, types and functions for the watermark cell pattern
`timescale 1ns / 1ps
package kwcp_pkg;
    localparam int GRID_CELLS_DEF     = 1024;
    localparam int TOTAL_CELLS_DEF    = 1024;
    localparam int DATA_CELLS_DEF     = 960;
    localparam int REPEAT_PER_BIT_DEF = 24;
    localparam int PAYLOAD_BITS_DEF   = 32;

    localparam logic [31:0] KEY_RESET  = 32'h5A17C0DE;
    localparam logic [31:0] MIX_MUL_A  = 32'h7FEB352D;
    localparam logic [31:0] MIX_MUL_B  = 32'h846CA68B;
    localparam logic [7:0]  CRC_POLY   = 8'h07;
    localparam logic [31:0] PILOT_SALT = 32'h50110000;
    localparam logic [31:0] PERM_SALT  = 32'h9E3779B9;

    localparam logic CFG_PAYLOAD = 1'b0;
    localparam logic CFG_KEY     = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_SH_HASH,
        ST_SH_DIV,
        ST_SH_RDI,
        ST_SH_RDJ,
        ST_SH_WR,
        ST_SH_WRJ,
        ST_RUN,
        ST_RD,
        ST_DONE
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load_item;
        logic init_step;
        logic hash_start;
        logic div_start;
        logic rd_i;
        logic rd_j;
        logic wr_swap;
        logic wr_j;
        logic run_start;
        logic rd_cell;
        logic out_load;
        logic built_set;
    } cmd_t;

    typedef struct packed {
        logic init_last;
        logic hash_done;
        logic div_done;
        logic shuffle_last;
        logic built;
    } status_t;

    function automatic logic [7:0] crc8_word(input logic [31:0] w);
        logic [7:0] c;
        c = 8'h00;
        for (int b = 0; b < 4; b++) begin
            c = c ^ w[8*b +: 8];
            for (int k = 0; k < 8; k++) begin
                c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
            end
        end
        return c;
    endfunction
endpackage

// ===== src/keyed_watermark_cell_pattern_top.sv =====
// Top level: keyed watermark cell pattern generator
`timescale 1ns / 1ps
// Describes one watermark cell per item: scrambled grid slot, +1/-1 amplitude,
// pilot flag and coded bit index. One item at a time. After reset or a key
// write the first item first builds the position permutation: an identity
// fill of all GRID_CELLS slots, then GRID_CELLS-1 swaps, each made of a hash,
// the bit-serial remainder unit, reads of slots i and j and writes of both.
// Otherwise the result is loaded after two chained passes through the shared
// two-multiply hash unit, one table read and the output load, and the next
// item is accepted once the block is back in idle. A result still held in
// the stalled output register delays the load.
module keyed_watermark_cell_pattern_top
#(
    parameter int GRID_CELLS     = kwcp_pkg::GRID_CELLS_DEF,
    parameter int DATA_CELLS     = kwcp_pkg::DATA_CELLS_DEF,
    parameter int REPEAT_PER_BIT = kwcp_pkg::REPEAT_PER_BIT_DEF,
    parameter int PAYLOAD_BITS   = kwcp_pkg::PAYLOAD_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [9:0]        cell_index,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [9:0]        grid_position,
    output logic signed [1:0] amplitude,
    output logic              is_pilot,
    output logic [5:0]        bit_index,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [0:0]        cfg_index,
    input  logic [31:0]       cfg_data
);
    import kwcp_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    kwcp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    kwcp_datapath
    #(
        .GRID_CELLS     (GRID_CELLS),
        .DATA_CELLS     (DATA_CELLS),
        .REPEAT_PER_BIT (REPEAT_PER_BIT),
        .PAYLOAD_BITS   (PAYLOAD_BITS)
    ) u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_wr_payload (cfg_valid && cfg_ready && (cfg_index == CFG_PAYLOAD)),
        .cfg_wr_key     (cfg_valid && cfg_ready && (cfg_index == CFG_KEY)),
        .cfg_data       (cfg_data),
        .cell_index     (cell_index),
        .grid_position  (grid_position),
        .amplitude      (amplitude),
        .is_pilot       (is_pilot),
        .bit_index      (bit_index)
    );
endmodule

// ===== src/kwcp_mix.sv =====
// Multi-cycle xorshift-multiply hash unit: one multiply per cycle, registered between steps
`timescale 1ns / 1ps
module kwcp_mix
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] din,
    output logic        done,
    output logic [31:0] dout
);
    import kwcp_pkg::*;

    logic [31:0] v_reg, v_next;
    logic [1:0]  step_reg, step_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [31:0] t;

    always_comb
    begin
        v_next    = v_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        t         = 32'd0;
        if (start)
        begin
            v_next    = din ^ (din >> 16);
            step_next = 2'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            unique case (step_reg)
                2'd0:
                begin
                    t      = v_reg * MIX_MUL_A;
                    v_next = t ^ (t >> 15);
                end
                2'd1:
                begin
                    t         = v_reg * MIX_MUL_B;
                    v_next    = t ^ (t >> 16);
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
            step_next = step_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
    end

    assign done = done_reg;
    assign dout = v_reg;
endmodule

// ===== src/kwcp_div.sv =====
// Restoring remainder unit: one quotient bit per cycle
`timescale 1ns / 1ps
module kwcp_div
#(
    parameter int DW = 13
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [31:0]   num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [DW-1:0] rem
);
    logic [DW:0]   r_reg, r_next;
    logic [31:0]   n_reg, n_next;
    logic [DW-1:0] d_reg;
    logic [5:0]    cnt_reg, cnt_next;
    logic          busy_reg, busy_next, done_reg, done_next;
    logic [DW+1:0] sh;

    always_comb
    begin
        r_next    = r_reg;
        n_next    = n_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        sh        = '0;
        if (start)
        begin
            r_next    = '0;
            n_next    = num;
            cnt_next  = 6'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            sh = {r_reg, n_reg[31]};
            if (sh >= {2'b00, d_reg})
            begin
                sh = sh - {2'b00, d_reg};
            end
            r_next   = sh[DW:0];
            n_next   = n_reg << 1;
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        n_reg <= n_next;
        if (start)
        begin
            d_reg <= den;
        end
    end

    assign done = done_reg;
    assign rem  = r_reg[DW-1:0];
endmodule

// ===== src/kwcp_datapath.sv =====
// Datapath: position memory, shuffle indexes, hashes and result registers
`timescale 1ns / 1ps
module kwcp_datapath
#(
    parameter int GRID_CELLS     = kwcp_pkg::GRID_CELLS_DEF,
    parameter int DATA_CELLS     = kwcp_pkg::DATA_CELLS_DEF,
    parameter int REPEAT_PER_BIT = kwcp_pkg::REPEAT_PER_BIT_DEF,
    parameter int PAYLOAD_BITS   = kwcp_pkg::PAYLOAD_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  kwcp_pkg::cmd_t       cmd,
    output kwcp_pkg::status_t    status,
    input  logic                 cfg_wr_payload,
    input  logic                 cfg_wr_key,
    input  logic [31:0]          cfg_data,
    input  logic [9:0]           cell_index,
    output logic [9:0]           grid_position,
    output logic signed [1:0]    amplitude,
    output logic                 is_pilot,
    output logic [5:0]           bit_index
);
    import kwcp_pkg::*;

    localparam int AW = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
    localparam int DW = AW + 1;

    // reciprocals for the constant divisions of the 10-bit cell number
    localparam int RCP_SH = 24;
    localparam logic [24:0] GRID_RCP =
        25'(((1 << RCP_SH) + GRID_CELLS - 1) / GRID_CELLS);
    localparam logic [24:0] REP_RCP =
        25'(((1 << RCP_SH) + REPEAT_PER_BIT - 1) / REPEAT_PER_BIT);

    logic [31:0] payload_reg, key_reg;
    logic        built_reg;
    logic [9:0]  cell_reg;
    logic [AW-1:0] i_reg, i_next, j_reg;
    logic [9:0]  vi_reg, vj_reg;
    logic [9:0]  mem [GRID_CELLS];
    logic [9:0]  rd_reg;
    logic [1:0]  phase_reg;     // run phase: 0 inner hash, 1 outer hash
    logic        neg_reg;
    logic [5:0]  bit_reg;

    // hash unit input select
    logic        mix_start, mix_done, div_done;
    logic [31:0] mix_in, mix_out;
    logic [DW-1:0] div_rem;
    logic        cell_pilot;
    logic [10:0] bit_full;
    logic [7:0]  copy_idx;
    logic        second, coded_set;
    logic [63:0] coded;
    logic [34:0] rep_prod, grid_prod;
    logic [10:0] grid_q;
    logic [31:0] copy_full, grid_rem;

    assign cell_pilot = ({22'd0, cell_reg} >= 32'(DATA_CELLS));
    assign rep_prod   = {25'd0, cell_reg} * {10'd0, REP_RCP};
    assign bit_full   = rep_prod[34:24];
    assign copy_full  = {22'd0, cell_reg} - {21'd0, bit_full} * 32'(REPEAT_PER_BIT);
    assign copy_idx   = copy_full[7:0];
    assign grid_prod  = {25'd0, cell_reg} * {10'd0, GRID_RCP};
    assign grid_q     = grid_prod[34:24];
    assign grid_rem   = {22'd0, cell_reg} - {21'd0, grid_q} * 32'(GRID_CELLS);
    assign second     = ({24'd0, copy_idx} >= 32'(REPEAT_PER_BIT / 2));
    assign coded      = {32'd0, payload_reg} |
                        ({56'd0, crc8_word(payload_reg)} << PAYLOAD_BITS);
    assign coded_set  = (bit_full < 11'd64) ? coded[bit_full[5:0]] : 1'b0;

    always_comb
    begin
        mix_start = cmd.hash_start || cmd.run_start;
        mix_in    = 32'd0;
        if (cmd.hash_start)
        begin
            mix_in = key_reg + PERM_SALT + 32'(i_reg);
        end
        else if (cmd.run_start)
        begin
            mix_in = cell_pilot ? ({22'd0, cell_reg} + PILOT_SALT)
                                : {21'd0, bit_full};
        end
        else if (phase_reg == 2'd0 && mix_done)
        begin
            mix_start = 1'b1;
            mix_in    = key_reg ^ mix_out;
        end
    end

    kwcp_mix u_mix
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mix_start),
        .din   (mix_in),
        .done  (mix_done),
        .dout  (mix_out)
    );

    kwcp_div #(.DW(DW)) u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (mix_out),
        .den   (DW'({1'b0, i_reg} + 1'b1)),
        .done  (div_done),
        .rem   (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            payload_reg <= 32'd0;
            key_reg     <= KEY_RESET;
            built_reg   <= 1'b0;
            phase_reg   <= 2'd0;
        end
        else
        begin
            if (cfg_wr_payload)
            begin
                payload_reg <= cfg_data;
            end
            if (cfg_wr_key)
            begin
                key_reg   <= cfg_data;
                built_reg <= 1'b0;
            end
            else if (cmd.built_set)
            begin
                built_reg <= 1'b1;
            end
            if (cmd.run_start || cmd.hash_start)
            begin
                phase_reg <= cmd.run_start ? 2'd0 : 2'd2;
            end
            else if (phase_reg == 2'd0 && mix_done)
            begin
                phase_reg <= 2'd1;
            end
        end
    end

    always_comb
    begin
        i_next = i_reg;
        if (cmd.load_item)
        begin
            i_next = '0;
        end
        else if (cmd.init_step)
        begin
            i_next = (i_reg == AW'(GRID_CELLS - 1)) ? AW'(GRID_CELLS - 1) : i_reg + 1'b1;
        end
        else if (cmd.wr_j)
        begin
            i_next = i_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg <= i_next;
        if (cmd.load_item)
        begin
            cell_reg <= cell_index;
        end
        if (div_done)
        begin
            j_reg <= div_rem[AW-1:0];
        end
        if (cmd.init_step)
        begin
            mem[i_reg] <= 10'(i_reg);
        end
        else if (cmd.wr_swap)
        begin
            mem[i_reg] <= vj_reg;
        end
        else if (cmd.wr_j)
        begin
            mem[j_reg] <= vi_reg;
        end
        if (cmd.rd_i)
        begin
            vi_reg <= mem[i_reg];
        end
        if (cmd.rd_j)
        begin
            vj_reg <= mem[j_reg];
        end
        if (cmd.rd_cell)
        begin
            rd_reg <= mem[AW'(grid_rem)];
        end
        if (phase_reg == 2'd1 && mix_done)
        begin
            neg_reg <= cell_pilot ? mix_out[0] : ((second != mix_out[0]) == coded_set);
            bit_reg <= cell_pilot ? 6'd0 : bit_full[5:0];
        end
        if (cmd.out_load)
        begin
            grid_position <= rd_reg;
            amplitude     <= neg_reg ? 2'sb11 : 2'sb01;
            is_pilot      <= cell_pilot;
            bit_index     <= bit_reg;
        end
    end

    assign status.init_last    = (i_reg == AW'(GRID_CELLS - 1));
    assign status.hash_done    = mix_done && (phase_reg != 2'd0);
    assign status.div_done     = div_done;
    assign status.shuffle_last = (i_reg == AW'(1));
    assign status.built        = built_reg;
endmodule

// ===== src/kwcp_ctrl.sv =====
// Controller: permutation build sequence and per-item sequencing
`timescale 1ns / 1ps
`include "keyed_watermark_cell_pattern_top_assert.svh"
module kwcp_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    output kwcp_pkg::cmd_t      cmd,
    input  kwcp_pkg::status_t   status
);
    import kwcp_pkg::*;

    state_t state_reg, state_next;
    logic   ovalid_reg, ovalid_next;
    logic   ovalid_load;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (in_valid) state_next = status.built ? ST_RUN : ST_INIT;
            ST_INIT:    if (status.init_last) state_next = ST_SH_HASH;
            ST_SH_HASH: if (status.hash_done) state_next = ST_SH_DIV;
            ST_SH_DIV:  if (status.div_done) state_next = ST_SH_RDI;
            ST_SH_RDI:  state_next = ST_SH_RDJ;
            ST_SH_RDJ:  state_next = ST_SH_WR;
            ST_SH_WR:   state_next = ST_SH_WRJ;
            ST_SH_WRJ:  state_next = status.shuffle_last ? ST_RUN : ST_SH_HASH;
            ST_RUN:     if (status.hash_done) state_next = ST_RD;
            ST_RD:      state_next = ST_DONE;
            ST_DONE:    if (!ovalid_reg || !out_stall) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    logic sh_first, run_first;
    logic prev_hash_reg, prev_run_reg;

    always_comb
    begin
        cmd         = '0;
        in_stall    = (state_reg != ST_IDLE);
        ovalid_load = 1'b0;
        cmd.load_item = (state_reg == ST_IDLE) && in_valid;
        unique case (state_reg)
            ST_INIT:    cmd.init_step = 1'b1;
            ST_SH_HASH: cmd.hash_start = sh_first;
            ST_SH_RDI:  cmd.rd_i = 1'b1;
            ST_SH_RDJ:  cmd.rd_j = 1'b1;
            ST_SH_WR:   cmd.wr_swap = 1'b1;
            // second half of the swap: write old table[i] to slot j
            ST_SH_WRJ:
            begin
                cmd.wr_j      = 1'b1;
                cmd.built_set = status.shuffle_last;
            end
            ST_RUN:     cmd.run_start = run_first;
            ST_RD:      cmd.rd_cell = 1'b1;
            ST_DONE:
            begin
                if (!ovalid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    ovalid_load  = 1'b1;
                end
            end
            default:    ;
        endcase
        if (state_reg == ST_SH_HASH && status.hash_done)
        begin
            cmd.div_start = 1'b1;
        end
    end

    assign sh_first  = !prev_hash_reg;
    assign run_first = !prev_run_reg;

    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (ovalid_load)
        begin
            ovalid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ovalid_reg    <= 1'b0;
            prev_hash_reg <= 1'b0;
            prev_run_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ovalid_reg    <= ovalid_next;
            prev_hash_reg <= (state_reg == ST_SH_HASH) && (state_next == ST_SH_HASH);
            prev_run_reg  <= (state_reg == ST_RUN) && (state_next == ST_RUN);
        end
    end

    assign out_valid = ovalid_reg;

    `KWCP_ASSERT_IMPL(a_no_accept_busy, (state_reg != ST_IDLE), in_stall)
    `KWCP_ASSERT_NEXT(a_load_valid, ovalid_load, out_valid)
    `KWCP_ASSERT_NEXT(a_stall_hold, (out_valid && out_stall), out_valid)
    `KWCP_ASSERT_IMPL(a_build_done_run, cmd.built_set, (state_next == ST_RUN))
endmodule

// ===== test/keyed_watermark_cell_pattern_top_test.sv =====
// Testbench for the keyed watermark cell pattern block: directed table plus random cells
`timescale 1ns / 1ps
module keyed_watermark_cell_pattern_top_test;
    import kwcp_pkg::*;

    localparam int GRID      = 1024;
    localparam int DATA      = 960;
    localparam int REPEAT    = 24;
    localparam int IDLE_MAX  = 200000;
    localparam int PER_PHASE = 290;

    typedef struct packed {
        logic [9:0]        slot;
        logic signed [1:0] amp;
        logic              pilot;
        logic [5:0]        bitno;
    } cell_desc_t;

    typedef struct {
        logic [9:0] cell_no;
        bit         fixed;
        logic       pilot;
        logic [5:0] bitno;
    } row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [9:0]        cell_index = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [9:0]        grid_position;
    logic signed [1:0] amplitude;
    logic              is_pilot;
    logic [5:0]        bit_index;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [0:0]        cfg_index = '0;
    logic [31:0]       cfg_data = '0;

    keyed_watermark_cell_pattern_top dut (.*);

    always #1 clk = ~clk;

    // shadow of the block's registers and permutation
    logic [31:0] pay_r;
    logic [31:0] key_r;
    logic [9:0]  slot_map [GRID];
    bit          map_ok;

    cell_desc_t  desc_q[$];
    cell_desc_t  fix_q[$];
    bit          fix_flag_q[$];
    int          errors = 0;
    int          idle_cycles = 0;
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;

    function automatic logic [31:0] mix(input logic [31:0] v);
        v = v ^ (v >> 16);
        v = v * 32'h7FEB352D;
        v = v ^ (v >> 15);
        v = v * 32'h846CA68B;
        v = v ^ (v >> 16);
        return v;
    endfunction

    function automatic logic [7:0] crc_of(input logic [31:0] w);
        logic [7:0] c;
        c = 8'h00;
        for (int b = 0; b < 32; b++) begin
            if (b % 8 == 0)
                c = c ^ w[b +: 8];
            c = c[7] ? ({c[6:0], 1'b0} ^ 8'h07) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    function automatic void shuffle_slots();
        logic [31:0] j;
        logic [9:0]  t;
        for (int i = 0; i < GRID; i++)
            slot_map[i] = i[9:0];
        for (int i = GRID - 1; i > 0; i--) begin
            j = mix(key_r + 32'h9E3779B9 + i) % (i + 1);
            t = slot_map[i];
            slot_map[i] = slot_map[j];
            slot_map[j] = t;
        end
        map_ok = 1'b1;
    endfunction

    function automatic cell_desc_t describe(input logic [9:0] cell_no);
        cell_desc_t d;
        logic [63:0] coded;
        logic [31:0] h;
        int          bitno;
        bit          neg;
        if (!map_ok)
            shuffle_slots();
        d.pilot = (cell_no >= DATA);
        d.bitno = '0;
        if (d.pilot) begin
            h = mix(key_r ^ mix({22'd0, cell_no} + 32'h50110000));
            neg = h[0];
        end else begin
            bitno = cell_no / REPEAT;
            d.bitno = bitno[5:0];
            h = mix(key_r ^ mix(bitno));
            neg = ((cell_no % REPEAT) >= REPEAT / 2) != h[0];
            coded = {24'd0, crc_of(pay_r), pay_r};
            if (!coded[bitno])
                neg = !neg;
        end
        d.slot = slot_map[cell_no];
        d.amp = neg ? 2'sb11 : 2'sb01;
        return d;
    endfunction

    // prediction on accepted items, checking on accepted results
    always @(posedge clk)
    begin
        cell_desc_t e;
        cell_desc_t f;
        bit         fx;
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_PAYLOAD)
                    pay_r = cfg_data;
                else begin
                    key_r = cfg_data;
                    map_ok = 1'b0;
                end
            end
            if (in_valid && !in_stall)
                desc_q.push_back(describe(cell_index));
            if (out_valid && !out_stall) begin
                if (desc_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result slot=%0d", $time, grid_position);
                end else begin
                    e = desc_q.pop_front();
                    f = fix_q.pop_front();
                    fx = fix_flag_q.pop_front();
                    if (fx) begin
                        e.pilot = f.pilot;
                        e.bitno = f.bitno;
                    end
                    if (grid_position !== e.slot || amplitude !== e.amp
                        || is_pilot !== e.pilot || bit_index !== e.bitno) begin
                        errors++;
                        $display("%0t: mismatch expected slot=%0d amp=%0d pilot=%0d bit=%0d",
                                 $time, e.slot, e.amp, e.pilot, e.bitno);
                        $display("%0t:          actual slot=%0d amp=%0d pilot=%0d bit=%0d",
                                 $time, grid_position, amplitude, is_pilot, bit_index);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_MAX) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < rx_stall_pct);

    task automatic send_cell(input logic [9:0] cell_no, input bit fixed,
                             input logic pilot, input logic [5:0] bitno);
        cell_desc_t f;
        f = '0;
        f.pilot = pilot;
        f.bitno = bitno;
        fix_q.push_back(f);
        fix_flag_q.push_back(fixed);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        cell_index <= cell_no;
        do @(posedge clk); while (!(in_valid && !in_stall));
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (desc_q.size() == 0);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_cells(input int n);
        for (int i = 0; i < n; i++) begin
            if (i == n / 3 && $urandom_range(1))
                drain();
            send_cell(10'($urandom_range(GRID - 1)), 1'b0, 1'b0, 6'd0);
        end
    endtask

    row_t dir_rows[] = '{
        '{10'd0,    1, 1'b0, 6'd0},  '{10'd1,    0, 1'b0, 6'd0},
        '{10'd11,   0, 1'b0, 6'd0},  '{10'd12,   0, 1'b0, 6'd0},
        '{10'd23,   0, 1'b0, 6'd0},  '{10'd24,   1, 1'b0, 6'd1},
        '{10'd341,  0, 1'b0, 6'd0},  '{10'd512,  0, 1'b0, 6'd0},
        '{10'd682,  0, 1'b0, 6'd0},  '{10'd767,  1, 1'b0, 6'd31},
        '{10'd768,  1, 1'b0, 6'd32}, '{10'd800,  0, 1'b0, 6'd0},
        '{10'd935,  1, 1'b0, 6'd38}, '{10'd936,  1, 1'b0, 6'd39},
        '{10'd959,  1, 1'b0, 6'd39}, '{10'd960,  1, 1'b1, 6'd0},
        '{10'd1000, 1, 1'b1, 6'd0},  '{10'd1023, 1, 1'b1, 6'd0},
        '{10'd0,    1, 1'b0, 6'd0}
    };

    initial
    begin
        pay_r = 32'd0;
        key_r = KEY_RESET;
        map_ok = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset register values first
        foreach (dir_rows[i])
            send_cell(dir_rows[i].cell_no, dir_rows[i].fixed,
                      dir_rows[i].pilot, dir_rows[i].bitno);

        tx_idle_pct = 19;
        rx_stall_pct = 62;
        write_reg(CFG_PAYLOAD, 32'hFFFF_FFFF);
        write_reg(CFG_KEY, 32'h0000_0000);
        random_cells(PER_PHASE);
        write_reg(CFG_PAYLOAD, 32'h0000_0000);
        for (int i = 0; i < PER_PHASE; i++)
        begin
            if (i == 100)
                drain();    // sender holds off until every result is back
            send_cell(10'($urandom_range(GRID - 1)), 1'b0, 1'b0, 6'd0);
        end

        tx_idle_pct = 62;
        rx_stall_pct = 19;
        write_reg(CFG_KEY, 32'hFFFF_FFFF);
        write_reg(CFG_PAYLOAD, $urandom);
        random_cells(PER_PHASE);
        write_reg(CFG_KEY, $urandom);
        random_cells(PER_PHASE);

        tx_idle_pct = 0;
        rx_stall_pct = 0;
        write_reg(CFG_PAYLOAD, $urandom);
        write_reg(CFG_KEY, $urandom);
        random_cells(PER_PHASE);
        write_reg(CFG_PAYLOAD, 32'h8000_0001);
        random_cells(PER_PHASE);

        drain();
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
